[hdl/dtti_pkg.sv]
package dtti_pkg;

    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ACC_W   = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [COUNT_W-1:0] DIGIT_MAX_COUNT = 5'd19;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 5'd31;

    // result_width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    // register indexes (paddr[2])
    localparam logic REG_RESULT_WIDTH = 1'b0;
    localparam logic REG_SIGNED_MODE  = 1'b1;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [COUNT_W-1:0] count;
        logic               neg;
        logic               bad;
    } field_t;

    function automatic logic [COUNT_W-1:0] len_unsigned(input logic [1:0] w);
        logic [COUNT_W-1:0] r;
        case (w)
            WIDTH_8:  r = 5'd3;
            WIDTH_16: r = 5'd5;
            WIDTH_32: r = 5'd10;
            default:  r = 5'd19;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] len_signed(input logic [1:0] w);
        logic [COUNT_W-1:0] r;
        case (w)
            WIDTH_8:  r = 5'd4;
            WIDTH_16: r = 5'd6;
            WIDTH_32: r = 5'd11;
            default:  r = 5'd20;
        endcase
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] max_unsigned(input logic [1:0] w);
        logic [ACC_W-1:0] r;
        case (w)
            WIDTH_8:  r = 64'd255;
            WIDTH_16: r = 64'd65535;
            WIDTH_32: r = 64'd4294967295;
            default:  r = 64'hffff_ffff_ffff_ffff;
        endcase
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] max_pos(input logic [1:0] w);
        logic [ACC_W-1:0] r;
        case (w)
            WIDTH_8:  r = 64'd127;
            WIDTH_16: r = 64'd32767;
            WIDTH_32: r = 64'd2147483647;
            default:  r = 64'h7fff_ffff_ffff_ffff;
        endcase
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] max_neg(input logic [1:0] w);
        logic [ACC_W-1:0] r;
        case (w)
            WIDTH_8:  r = 64'd128;
            WIDTH_16: r = 64'd32768;
            WIDTH_32: r = 64'd2147483648;
            default:  r = 64'h8000_0000_0000_0000;
        endcase
        return r;
    endfunction

endpackage

[hdl/dtti_check.sv]
module dtti_check
(
    input  dtti_pkg::field_t  field,
    input  logic [1:0]        result_width,
    input  logic              signed_mode,
    output logic [63:0]       value,
    output logic              status
);

    logic [dtti_pkg::COUNT_W-1:0] digits;
    logic [dtti_pkg::ACC_W-1:0]   negated;
    logic [dtti_pkg::ACC_W-1:0]   result;
    logic                         err;

    assign digits  = field.count - {{(dtti_pkg::COUNT_W-1){1'b0}}, field.neg};
    assign negated = {dtti_pkg::ACC_W{1'b0}} - field.acc;

    always_comb
    begin
        err    = field.bad || (digits == '0) || (digits > dtti_pkg::DIGIT_MAX_COUNT);
        result = field.acc;
        if (signed_mode)
        begin
            if (field.count > dtti_pkg::len_signed(result_width))
                err = 1'b1;
            if (field.neg)
            begin
                if (field.acc > dtti_pkg::max_neg(result_width))
                    err = 1'b1;
                result = negated;
            end
            else if (field.acc > dtti_pkg::max_pos(result_width))
            begin
                err = 1'b1;
            end
        end
        else
        begin
            // a minus taken while signed mode was on makes the field an error once it is off
            if (field.neg || (field.count > dtti_pkg::len_unsigned(result_width)))
                err = 1'b1;
            if (field.acc > dtti_pkg::max_unsigned(result_width))
                err = 1'b1;
        end
    end

    assign value  = err ? 64'd0 : result;
    assign status = err;

endmodule

[hdl/decimal_text_to_integer_core.sv]
// Decimal text to integer: takes one ASCII character per item on the slave
// stream, with tlast on the last character of a field, and gives one result
// item per field on the master stream: the value sign-extended (signed mode)
// or zero-extended to 64 bits in tdata, and tuser high on a format, length
// or range error (tdata is then zero). One character is accepted every
// clock; only a last character can be held back, and only while the result
// stream stalls with a result still waiting behind the output register. The
// result goes from the input register through the field register (last
// step of the times-ten-plus-digit accumulation) into the output register.
// Set result_width (address 0) and signed_mode (address 4) only while no
// field is in flight.
module decimal_text_to_integer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // field_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic        m_tuser,   // status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [1:0] result_width_reg;
    logic       signed_mode_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == dtti_pkg::REG_SIGNED_MODE)
                       ? {31'd0, signed_mode_reg} : {30'd0, result_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_width_reg <= dtti_pkg::WIDTH_64;
            signed_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dtti_pkg::REG_RESULT_WIDTH)
                result_width_reg <= pwdata[1:0];
            else
                signed_mode_reg <= pwdata[0];
        end
    end

    // handshake chain
    logic in_valid_reg;
    logic in_last_reg;
    logic [7:0] in_char_reg;
    logic fin_valid_reg;
    logic out_ready;
    logic fin_ready;
    logic fin_fire;
    logic in_fire;
    logic s_fire;

    assign out_ready = !m_tvalid || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign fin_fire  = fin_valid_reg && out_ready;
    assign in_fire   = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_tready  = !in_valid_reg || in_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (in_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // accumulator stage
    dtti_pkg::field_t state_reg;
    dtti_pkg::field_t state_next;
    dtti_pkg::field_t fin_reg;
    logic [dtti_pkg::COUNT_W-1:0] digits;
    logic [3:0] digit;
    logic is_digit;

    assign digits   = state_reg.count - {{(dtti_pkg::COUNT_W-1){1'b0}}, state_reg.neg};
    assign is_digit = (in_char_reg >= dtti_pkg::CHAR_ZERO) && (in_char_reg <= dtti_pkg::CHAR_NINE);
    assign digit    = in_char_reg[3:0];

    always_comb
    begin
        state_next = state_reg;
        if ((in_char_reg == dtti_pkg::CHAR_MINUS) && (state_reg.count == '0) && signed_mode_reg)
        begin
            state_next.neg = 1'b1;
        end
        else if (is_digit)
        begin
            if ((digits < dtti_pkg::DIGIT_MAX_COUNT) && !state_reg.bad)
                // times ten as shift-add; at most 19 digits, so no wrap
                state_next.acc = {state_reg.acc[60:0], 3'b000}
                               + {state_reg.acc[62:0], 1'b0}
                               + {60'd0, digit};
            else
                state_next.bad = 1'b1;
        end
        else
        begin
            state_next.bad = 1'b1;
        end
        if (state_reg.count < dtti_pkg::COUNT_MAX)
            state_next.count = state_reg.count + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_last_reg)
                state_reg <= '0;
            else
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (in_fire && in_last_reg)
            fin_valid_reg <= 1'b1;
        else if (fin_fire)
            fin_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_last_reg)
            fin_reg <= state_next;
    end

    // range check and output register
    logic [63:0] chk_value;
    logic        chk_status;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    dtti_check u_check
    (
        .field        (fin_reg),
        .result_width (result_width_reg),
        .signed_mode  (signed_mode_reg),
        .value        (chk_value),
        .status       (chk_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (fin_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            m_tdata_reg <= chk_value;
            m_tuser_reg <= chk_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
